// ===== hdl/ddo_pkg.sv =====
`timescale 1ns / 1ps

package ddo_pkg;

   // serial multiplier operand and product widths
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = 64;

   // serial divider dividend and divisor widths
   localparam int DIV_N_W = 34;
   localparam int DIV_D_W = 17;

   // arctangent table
   localparam int ATAN_COUNT = 24;
   localparam int ANG_IDX_W  = 5;

   localparam logic signed [31:0] INV_GAIN_Q28      = 32'sd163008218;
   localparam logic [31:0]        UNITS_PER_RAD_Q16 = 32'd683565276;
   localparam logic [15:0]        TRACK_WIDTH_RESET = 16'd2560;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_TH,
      ST_DIV_TH,
      ST_COS_OLD,
      ST_COS_NEW,
      ST_MUL_SX,
      ST_MUL_SY,
      ST_MUL_WS,
      ST_MUL_AX,
      ST_DIV_AX,
      ST_MUL_AY,
      ST_DIV_AY,
      ST_FINISH
   } ddo_state_type;

   // atan(2^-i) in 2^-32 turn units
   function automatic logic [31:0] atan_entry(input logic [ANG_IDX_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933406;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10679838;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335087;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41722;
         5'd15:   r = 32'd20861;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2608;
         5'd19:   r = 32'd1304;
         5'd20:   r = 32'd652;
         5'd21:   r = 32'd326;
         5'd22:   r = 32'd163;
         5'd23:   r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] abs17(input logic signed [16:0] v);
      return v[16] ? 17'(-v) : 17'(v);
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

endpackage

// ===== hdl/ddo_mul_serial.sv =====
`timescale 1ns / 1ps

module ddo_mul_serial (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ddo_pkg::MUL_A_W-1:0] a,
   input  logic [ddo_pkg::MUL_B_W-1:0] b,
   output logic                        done,
   output logic [ddo_pkg::MUL_P_W-1:0] product
);
   import ddo_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [MUL_P_W-1:0] acc_ff, acc_in;

   // msb first shift and add, one multiplier bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[MUL_P_W-2:0], 1'b0} + (b_ff[MUL_B_W-1] ? MUL_P_W'(a_ff) : '0);
         b_in   = {b_ff[MUL_B_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== hdl/ddo_div_serial.sv =====
`timescale 1ns / 1ps

module ddo_div_serial (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ddo_pkg::DIV_N_W-1:0] dividend,
   input  logic [ddo_pkg::DIV_D_W-1:0] divisor,
   output logic                        done,
   output logic [ddo_pkg::DIV_N_W-1:0] quotient
);
   import ddo_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] n_ff, n_in;
   logic [DIV_N_W-1:0] q_ff, q_in;
   logic [DIV_D_W-1:0] d_ff, d_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W:0]   trial;
   logic               fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, n_ff[DIV_N_W-1]};
      fits    = trial >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = dividend;
         q_in    = '0;
         d_in    = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_D_W'(trial - {1'b0, d_ff}) : DIV_D_W'(trial);
         q_in   = {q_ff[DIV_N_W-2:0], fits};
         n_in   = {n_ff[DIV_N_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== hdl/ddo_cordic.sv =====
`timescale 1ns / 1ps

module ddo_cordic #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        angle,
   output logic               done,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);
   import ddo_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 flip_ff, flip_in;
   logic [ANG_IDX_W-1:0] idx_ff, idx_in;
   logic signed [31:0]   x_ff, x_in;
   logic signed [31:0]   y_ff, y_in;
   logic signed [31:0]   z_ff, z_in;
   logic signed [31:0]   xs, ys, at;
   logic                 fold;

   // one rotation stage per cycle
   always_comb begin
      fold    = angle[15] ^ angle[14];
      xs      = x_ff >>> idx_ff;
      ys      = y_ff >>> idx_ff;
      at      = signed'(atan_entry(idx_ff));
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         flip_in = fold;
         idx_in  = '0;
         x_in    = INV_GAIN_Q28;
         y_in    = '0;
         // second and third quadrant fold by a half turn
         z_in    = signed'({angle[15] ^ fold, angle[14:0], 16'd0});
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == ANG_IDX_W'(STAGES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff <= flip_in;
      idx_ff  <= idx_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

// ===== hdl/differential_drive_odometry.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// req       in         req_valid/stall    left_step, right_step (signed 16)
// rsp       out        rsp_valid/stall    pos_x, pos_y (signed 32), heading (16)
// csr       in         csr_write_enable   csr_write_data = track width (16)
//
// one transaction at a time through a sequencer around a bit-serial multiplier,
// a bit-serial restoring divider and an iterative cordic (one stage a cycle)
// both moves run a multiplier, a divider and a cordic pass; a straight move then
// two multiplier passes, an arc move a second cordic pass, a multiplier pass and
// a multiplier and a divider pass per axis; the result shows as req_stall drops
// synchronous active-high reset clears pose, sequencer and rsp_valid, and
// loads the track width with 2560
// the pose is committed only once the result register is free, so rsp stall
// holds the sequencer in its final state

module differential_drive_odometry #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_left_step,
   input  logic signed [15:0] req_right_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [15:0]        rsp_heading
);
   import ddo_pkg::*;

   ddo_state_type state_ff, state_in;

   // configuration and pose
   logic [15:0]        track_width_ff, track_width_in;
   logic [31:0]        x_ff, x_in;
   logic [31:0]        y_ff, y_in;
   logic [15:0]        heading_ff, heading_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-transaction working registers
   logic signed [16:0] sum_ff, sum_in;
   logic signed [16:0] off_ff, off_in;
   logic [15:0]        w_ff, w_in;
   logic               dth_nz_ff, dth_nz_in;
   logic [15:0]        new_h_ff, new_h_in;
   logic signed [31:0] co_ff, co_in;
   logic signed [31:0] so_ff, so_in;
   logic signed [31:0] cn_ff, cn_in;
   logic signed [31:0] sn_ff, sn_in;
   logic [32:0]        ws_ff, ws_in;
   logic [31:0]        dx_ff, dx_in;
   logic [31:0]        dy_ff, dy_in;

   // shared unit controls
   logic               mul_start, mul_done;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_product;
   logic               div_start, div_done;
   logic [DIV_N_W-1:0] div_n, div_q;
   logic [DIV_D_W-1:0] div_d;
   logic               cor_start, cor_done;
   logic [15:0]        cor_angle;
   logic signed [31:0] cor_cos, cor_sin;

   // datapath helpers
   logic signed [16:0] off_now;
   logic signed [31:0] diff_x, diff_y;
   logic [MUL_P_W-1:0] th_num, arc_num, st_num;
   logic [DIV_N_W-1:0] arc_q_neg;
   logic [31:0]        st_mag;
   logic [15:0]        dth16;
   logic               proceed;

   assign off_now = 17'(req_right_step) - 17'(req_left_step);
   assign diff_x  = sn_ff - so_ff;
   assign diff_y  = co_ff - cn_ff;
   // rounding offsets folded in before the power-of-two part of each divide
   assign th_num  = mul_product + (MUL_P_W'(w_ff) << 15);
   assign arc_num = mul_product + (MUL_P_W'(abs17(off_ff)) << 28);
   assign st_num  = mul_product + (MUL_P_W'(1) << 28);
   assign st_mag  = 32'(st_num >> 29);
   assign arc_q_neg = -div_q;
   assign dth16   = off_ff[16] ? 16'(-div_q[15:0]) : div_q[15:0];
   // commit only into a free (or emptying) result register
   assign proceed = !rsp_valid_ff || !rsp_stall;

   ddo_mul_serial u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   ddo_div_serial u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   ddo_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MUL_TH;
         ST_MUL_TH:  if (mul_done) state_in = ST_DIV_TH;
         ST_DIV_TH:  if (div_done) state_in = ST_COS_OLD;
         ST_COS_OLD: if (cor_done) state_in = dth_nz_ff ? ST_COS_NEW : ST_MUL_SX;
         ST_MUL_SX:  if (mul_done) state_in = ST_MUL_SY;
         ST_MUL_SY:  if (mul_done) state_in = ST_FINISH;
         ST_COS_NEW: if (cor_done) state_in = ST_MUL_WS;
         ST_MUL_WS:  if (mul_done) state_in = ST_MUL_AX;
         ST_MUL_AX:  if (mul_done) state_in = ST_DIV_AX;
         ST_DIV_AX:  if (div_done) state_in = ST_MUL_AY;
         ST_MUL_AY:  if (mul_done) state_in = ST_DIV_AY;
         ST_DIV_AY:  if (div_done) state_in = ST_FINISH;
         ST_FINISH:  if (proceed) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // unit launches
   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_n     = '0;
      div_d     = '0;
      cor_start = 1'b0;
      cor_angle = heading_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            // |offset| * units per radian
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(abs17(off_now));
            mul_b     = UNITS_PER_RAD_Q16;
         end
         ST_MUL_TH: if (mul_done) begin
            div_start = 1'b1;
            div_n     = DIV_N_W'(th_num >> 16);
            div_d     = DIV_D_W'(w_ff);
         end
         ST_DIV_TH: if (div_done) begin
            cor_start = 1'b1;
            cor_angle = heading_ff;
         end
         ST_COS_OLD: if (cor_done) begin
            if (dth_nz_ff) begin
               cor_start = 1'b1;
               cor_angle = new_h_ff;
            end else begin
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(abs17(sum_ff));
               mul_b     = abs32(cor_cos);
            end
         end
         ST_MUL_SX: if (mul_done) begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(abs17(sum_ff));
            mul_b     = abs32(so_ff);
         end
         ST_COS_NEW: if (cor_done) begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(w_ff);
            mul_b     = MUL_B_W'(abs17(sum_ff));
         end
         ST_MUL_WS: if (mul_done) begin
            mul_start = 1'b1;
            mul_a     = mul_product[MUL_A_W-1:0];
            mul_b     = abs32(diff_x);
         end
         ST_MUL_AX: if (mul_done) begin
            div_start = 1'b1;
            div_n     = DIV_N_W'(arc_num >> 29);
            div_d     = abs17(off_ff);
         end
         ST_DIV_AX: if (div_done) begin
            mul_start = 1'b1;
            mul_a     = ws_ff;
            mul_b     = abs32(diff_y);
         end
         ST_MUL_AY: if (mul_done) begin
            div_start = 1'b1;
            div_n     = DIV_N_W'(arc_num >> 29);
            div_d     = abs17(off_ff);
         end
         default: begin
         end
      endcase
   end

   // register next values
   always_comb begin
      track_width_in = csr_write_enable ? csr_write_data : track_width_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      heading_in     = heading_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      sum_in         = sum_ff;
      off_in         = off_ff;
      w_in           = w_ff;
      dth_nz_in      = dth_nz_ff;
      new_h_in       = new_h_ff;
      co_in          = co_ff;
      so_in          = so_ff;
      cn_in          = cn_ff;
      sn_in          = sn_ff;
      ws_in          = ws_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            sum_in = 17'(req_right_step) + 17'(req_left_step);
            off_in = off_now;
            // zero track width behaves as one
            w_in   = (track_width_ff == '0) ? 16'd1 : track_width_ff;
         end
         ST_DIV_TH: if (div_done) begin
            dth_nz_in = div_q != '0;
            new_h_in  = heading_ff + dth16;
         end
         ST_COS_OLD: if (cor_done) begin
            co_in = cor_cos;
            so_in = cor_sin;
         end
         ST_MUL_SX: if (mul_done) begin
            dx_in = (sum_ff[16] ^ co_ff[31]) ? -st_mag : st_mag;
         end
         ST_MUL_SY: if (mul_done) begin
            dy_in = (sum_ff[16] ^ so_ff[31]) ? -st_mag : st_mag;
         end
         ST_COS_NEW: if (cor_done) begin
            cn_in = cor_cos;
            sn_in = cor_sin;
         end
         ST_MUL_WS: if (mul_done) begin
            ws_in = mul_product[MUL_A_W-1:0];
         end
         ST_DIV_AX: if (div_done) begin
            dx_in = (sum_ff[16] ^ off_ff[16] ^ diff_x[31]) ? arc_q_neg[31:0] : div_q[31:0];
         end
         ST_DIV_AY: if (div_done) begin
            dy_in = (sum_ff[16] ^ off_ff[16] ^ diff_y[31]) ? arc_q_neg[31:0] : div_q[31:0];
         end
         ST_FINISH: if (proceed) begin
            x_in         = x_ff + dx_ff;
            y_in         = y_ff + dy_ff;
            heading_in   = new_h_ff;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         track_width_ff <= TRACK_WIDTH_RESET;
         x_ff           <= '0;
         y_ff           <= '0;
         heading_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         track_width_ff <= track_width_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
         heading_ff     <= heading_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      off_ff    <= off_in;
      w_ff      <= w_in;
      dth_nz_ff <= dth_nz_in;
      new_h_ff  <= new_h_in;
      co_ff     <= co_in;
      so_ff     <= so_in;
      cn_ff     <= cn_in;
      sn_ff     <= sn_in;
      ws_ff     <= ws_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
   end

   // a new transaction is taken only while the sequencer is idle
   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = signed'(x_ff);
   assign rsp_pos_y   = signed'(y_ff);
   assign rsp_heading = heading_ff;

endmodule
